[rtl/core/scs_pkg.sv]
// Shared types, codes and helper functions of the segment clearance scan unit.
package scs_pkg;

  localparam int TABLE_DEPTH_DEF   = 256;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int CFG_W             = 9;

  localparam logic [30:0] MAX_Q31 = 31'h7FFF_FFFF;

  // command codes of an input word
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // product groups walked by the shared multiplier
  localparam logic [2:0] GRP_LEN   = 3'd0;
  localparam logic [2:0] GRP_DOT   = 3'd1;
  localparam logic [2:0] GRP_LSQ   = 3'd2;
  localparam logic [2:0] GRP_CROSS = 3'd3;
  localparam logic [2:0] GRP_NR    = 3'd4;
  localparam logic [2:0] GRP_NT    = 3'd5;

  typedef struct packed {
    logic               command;
    logic [7:0]         slot;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic [30:0]        threshold;
  } scs_in_t;

  typedef struct packed {
    logic       all_clear;
    logic [7:0] farthest_index;
    logic       farthest_found;
  } scs_res_t;

  typedef struct packed {
    logic       accept;
    logic       init_scan;
    logic       load_diff;
    logic       mul_en;
    logic       acc_en;
    logic       acc_first;
    logic       save_dot;
    logic       sqrt_start;
    logic       div_start;
    logic       save_n1;
    logic       set_d_norm;
    logic       set_d_div;
    logic       wr_len;
    logic       rd_en;
    logic       upd;
    logic [2:0] grp;
    logic [1:0] k;
  } scs_cmd_t;

  typedef struct packed {
    logic len_pos;
    logic in_range;
    logic sqrt_done;
    logic div_done;
    logic scan_done;
  } scs_sts_t;

  // a - b, saturated to the signed 32-bit range
  function automatic logic signed [31:0] sat_diff(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    logic signed [32:0] d;
    d = $signed({a[31], a}) - $signed({b[31], b});
    if (d[32] != d[31]) begin
      return d[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return d[31:0];
  endfunction

  // index of the last product in a group
  function automatic logic [1:0] grp_last(input logic [2:0] grp);
    return (grp == GRP_LSQ) ? 2'd0 : 2'd2;
  endfunction

  // groups that sum raw squares instead of Q-format products
  function automatic logic grp_square(input logic [2:0] grp);
    return (grp == GRP_LEN) || (grp == GRP_NR) || (grp == GRP_NT);
  endfunction

endpackage

[rtl/core/scs_isqrt.sv]
// Iterative integer square root, two radicand bits per cycle.
module scs_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] radicand_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic        run_q;
  logic [4:0]  cnt_q;
  logic        done_q;
  logic [63:0] x_q;
  logic [35:0] rem_q;
  logic [31:0] root_q;

  logic [35:0] rem_n;
  logic [35:0] trial;
  logic        ge;

  assign rem_n = {rem_q[33:0], x_q[63:62]};
  assign trial = {2'b00, root_q, 2'b01};
  assign ge    = rem_n >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 5'd31;
      end else if (run_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (run_q) begin
      x_q    <= {x_q[61:0], 2'b00};
      rem_q  <= ge ? (rem_n - trial) : rem_n;
      root_q <= {root_q[30:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

  a_done_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !run_q)
    else $error("root done while still iterating");

endmodule

[rtl/core/scs_div.sv]
// Restoring divider, one quotient bit per cycle.
module scs_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [30:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quotient_o
);

  logic        run_q;
  logic [5:0]  cnt_q;
  logic        done_q;
  logic [31:0] rem_q;
  logic [63:0] quo_q;
  logic [30:0] dvs_q;

  logic [31:0] rem_n;
  logic        ge;

  assign rem_n = {rem_q[30:0], quo_q[63]};
  assign ge    = rem_n >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 6'd63;
      end else if (run_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= ge ? (rem_n - {1'b0, dvs_q}) : rem_n;
      quo_q <= {quo_q[62:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[rtl/core/scs_dpath.sv]
// Datapath: segment table, difference registers, shared multiplier, root and divide units.
module scs_dpath #(
  parameter int TABLE_DEPTH   = scs_pkg::TABLE_DEPTH_DEF,
  parameter int FRACTION_BITS = scs_pkg::FRACTION_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  scs_pkg::scs_in_t         item_i,
  input  scs_pkg::scs_cmd_t        cmd_i,
  input  logic                     cfg_we_i,
  input  logic [scs_pkg::CFG_W-1:0] cfg_data_i,
  output scs_pkg::scs_sts_t        sts_o,
  output scs_pkg::scs_res_t        result_o
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int IW = (AW + 1 > scs_pkg::CFG_W) ? AW + 1 : scs_pkg::CFG_W;
  localparam logic [31:0] DEPTH_W = 32'(TABLE_DEPTH);

  // table
  logic signed [31:0] px_mem [TABLE_DEPTH];
  logic signed [31:0] py_mem [TABLE_DEPTH];
  logic signed [31:0] pz_mem [TABLE_DEPTH];
  logic signed [31:0] dx_mem [TABLE_DEPTH];
  logic signed [31:0] dy_mem [TABLE_DEPTH];
  logic signed [31:0] dz_mem [TABLE_DEPTH];
  logic signed [31:0] len_mem [TABLE_DEPTH];

  logic signed [31:0] rd_px_q, rd_py_q, rd_pz_q, rd_dx_q, rd_dy_q, rd_dz_q, rd_len_q;

  scs_pkg::scs_in_t   in_q;
  logic [scs_pkg::CFG_W-1:0] cfg_q;

  logic signed [31:0] sx_q, sy_q, sz_q, rx_q, ry_q, rz_q, tx_q, ty_q, tz_q, uy_q, len_q;
  logic signed [31:0] op_a, op_b;
  logic [31:0]        mag_a, mag_b;
  logic [63:0]        p_q;
  logic               neg_q;
  logic [63:0]        p_shift, term;
  logic signed [63:0] acc_q, dot_q;
  logic [63:0]        cross_mag;

  logic [31:0] root;
  logic [63:0] quo;
  logic        sqrt_done, div_done;
  logic [30:0] root_sat;

  logic [30:0] n1_q, d_q, best_q;
  logic [7:0]  bidx_q;
  logic        found_q, clear_q;
  logic [IW-1:0] idx_q;

  logic              is_load_q;
  logic              slot_ok_q;
  logic              coord_we;
  logic [AW-1:0]     wr_addr, len_addr, rd_addr;
  logic signed [31:0] p_x, p_y, p_z, d_x, d_y, d_z;

  assign coord_we = cmd_i.accept && (item_i.command == scs_pkg::CMD_LOAD) &&
                    ({24'b0, item_i.slot} < DEPTH_W);
  assign wr_addr  = AW'(item_i.slot);
  assign len_addr = AW'(in_q.slot);
  assign rd_addr  = idx_q[AW-1:0];
  assign root_sat = root[31] ? scs_pkg::MAX_Q31 : root[30:0];

  always_ff @(posedge clk_i) begin
    if (coord_we) begin
      px_mem[wr_addr] <= item_i.first_x;
      py_mem[wr_addr] <= item_i.first_y;
      pz_mem[wr_addr] <= item_i.first_z;
      dx_mem[wr_addr] <= item_i.second_x;
      dy_mem[wr_addr] <= item_i.second_y;
      dz_mem[wr_addr] <= item_i.second_z;
    end
    if (cmd_i.wr_len && slot_ok_q) begin
      len_mem[len_addr] <= {1'b0, root_sat};
    end
    if (cmd_i.rd_en) begin
      rd_px_q  <= px_mem[rd_addr];
      rd_py_q  <= py_mem[rd_addr];
      rd_pz_q  <= pz_mem[rd_addr];
      rd_dx_q  <= dx_mem[rd_addr];
      rd_dy_q  <= dy_mem[rd_addr];
      rd_dz_q  <= dz_mem[rd_addr];
      rd_len_q <= len_mem[rd_addr];
    end
  end

  // latch the input word
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      in_q      <= item_i;
      slot_ok_q <= {24'b0, item_i.slot} < DEPTH_W;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q     <= '0;
      is_load_q <= 1'b1;
    end else begin
      if (cfg_we_i) cfg_q <= cfg_data_i;
      if (cmd_i.accept) is_load_q <= (item_i.command == scs_pkg::CMD_LOAD);
    end
  end

  // endpoints come from the input word on a load, from the table on a query
  always_comb begin
    if (is_load_q) begin
      p_x = in_q.first_x;  p_y = in_q.first_y;  p_z = in_q.first_z;
      d_x = in_q.second_x; d_y = in_q.second_y; d_z = in_q.second_z;
    end else begin
      p_x = rd_px_q; p_y = rd_py_q; p_z = rd_pz_q;
      d_x = rd_dx_q; d_y = rd_dy_q; d_z = rd_dz_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_diff) begin
      sx_q  <= scs_pkg::sat_diff(p_x, d_x);
      sy_q  <= scs_pkg::sat_diff(p_y, d_y);
      sz_q  <= scs_pkg::sat_diff(p_z, d_z);
      rx_q  <= scs_pkg::sat_diff(in_q.first_x, d_x);
      ry_q  <= scs_pkg::sat_diff(in_q.first_y, d_y);
      rz_q  <= scs_pkg::sat_diff(in_q.first_z, d_z);
      tx_q  <= scs_pkg::sat_diff(in_q.first_x, p_x);
      ty_q  <= scs_pkg::sat_diff(in_q.first_y, p_y);
      tz_q  <= scs_pkg::sat_diff(in_q.first_z, p_z);
      uy_q  <= scs_pkg::sat_diff(d_y, p_y);
      len_q <= rd_len_q;
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    op_a = sx_q;
    op_b = sx_q;
    case ({cmd_i.grp, cmd_i.k})
      {scs_pkg::GRP_LEN, 2'd0}:   begin op_a = sx_q;  op_b = sx_q;  end
      {scs_pkg::GRP_LEN, 2'd1}:   begin op_a = sy_q;  op_b = sy_q;  end
      {scs_pkg::GRP_LEN, 2'd2}:   begin op_a = sz_q;  op_b = sz_q;  end
      {scs_pkg::GRP_DOT, 2'd0}:   begin op_a = sx_q;  op_b = rx_q;  end
      {scs_pkg::GRP_DOT, 2'd1}:   begin op_a = sy_q;  op_b = ry_q;  end
      {scs_pkg::GRP_DOT, 2'd2}:   begin op_a = sz_q;  op_b = rz_q;  end
      {scs_pkg::GRP_LSQ, 2'd0}:   begin op_a = len_q; op_b = len_q; end
      {scs_pkg::GRP_CROSS, 2'd0}: begin op_a = uy_q;  op_b = rx_q;  end
      {scs_pkg::GRP_CROSS, 2'd1}: begin op_a = sx_q;  op_b = ry_q;  end
      {scs_pkg::GRP_CROSS, 2'd2}: begin op_a = sz_q;  op_b = rz_q;  end
      {scs_pkg::GRP_NR, 2'd0}:    begin op_a = rx_q;  op_b = rx_q;  end
      {scs_pkg::GRP_NR, 2'd1}:    begin op_a = ry_q;  op_b = ry_q;  end
      {scs_pkg::GRP_NR, 2'd2}:    begin op_a = rz_q;  op_b = rz_q;  end
      {scs_pkg::GRP_NT, 2'd0}:    begin op_a = tx_q;  op_b = tx_q;  end
      {scs_pkg::GRP_NT, 2'd1}:    begin op_a = ty_q;  op_b = ty_q;  end
      {scs_pkg::GRP_NT, 2'd2}:    begin op_a = tz_q;  op_b = tz_q;  end
      default:                    begin op_a = sx_q;  op_b = sx_q;  end
    endcase
  end

  assign mag_a = op_a[31] ? (~op_a + 32'd1) : op_a;
  assign mag_b = op_b[31] ? (~op_b + 32'd1) : op_b;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      p_q   <= {32'b0, mag_a} * {32'b0, mag_b};
      neg_q <= op_a[31] ^ op_b[31];
    end
  end

  // truncate the magnitude, then put the sign back; squares add raw
  assign p_shift = p_q >> FRACTION_BITS;
  assign term    = scs_pkg::grp_square(cmd_i.grp) ? p_q :
                   (neg_q ? (~p_shift + 64'd1) : p_shift);

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_en) begin
      acc_q <= cmd_i.acc_first ? $signed(term) : acc_q + $signed(term);
    end
    if (cmd_i.save_dot) dot_q <= acc_q;
  end

  assign cross_mag = acc_q[63] ? (~acc_q + 64'd1) : acc_q;

  scs_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.sqrt_start),
    .radicand_i (acc_q),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  scs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (cross_mag << FRACTION_BITS),
    .divisor_i  (len_q[30:0]),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.save_n1) n1_q <= root_sat;
    if (cmd_i.set_d_norm) d_q <= (root_sat < n1_q) ? root_sat : n1_q;
    if (cmd_i.set_d_div) d_q <= (quo[63:31] != '0) ? scs_pkg::MAX_Q31 : quo[30:0];
  end

  // scan bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      clear_q <= 1'b1;
      found_q <= 1'b0;
      best_q  <= '0;
      bidx_q  <= '0;
    end else if (cmd_i.init_scan) begin
      idx_q   <= '0;
      clear_q <= 1'b1;
      found_q <= 1'b0;
      best_q  <= '0;
      bidx_q  <= '0;
    end else if (cmd_i.upd) begin
      idx_q <= idx_q + IW'(1);
      if (!(d_q > in_q.threshold)) clear_q <= 1'b0;
      if (d_q > best_q) begin
        best_q  <= d_q;
        bidx_q  <= idx_q[7:0];
        found_q <= 1'b1;
      end
    end
  end

  assign sts_o.len_pos   = !rd_len_q[31] && (rd_len_q != '0);
  assign sts_o.in_range  = !dot_q[63] && (dot_q <= acc_q);
  assign sts_o.sqrt_done = sqrt_done;
  assign sts_o.div_done  = div_done;
  assign sts_o.scan_done = (idx_q == IW'(cfg_q)) || (idx_q == IW'(TABLE_DEPTH));

  assign result_o.all_clear      = !is_load_q && clear_q;
  assign result_o.farthest_index = is_load_q ? 8'd0 : bidx_q;
  assign result_o.farthest_found = !is_load_q && found_q;

  a_found_has_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> (best_q != '0))
    else $error("farthest found without a positive distance");

  a_no_found_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !found_q |-> (bidx_q == '0))
    else $error("farthest index set without a hit");

endmodule

[rtl/core/scs_ctrl.sv]
// Controller: sequences loads, the per-segment product groups, root, divide and scan.
module scs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              is_query_i,
  input  scs_pkg::scs_sts_t sts_i,
  output logic              busy_o,
  output logic              result_valid_o,
  output scs_pkg::scs_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LDIFF = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_ACC   = 4'd3;
  localparam logic [3:0] S_POST  = 4'd4;
  localparam logic [3:0] S_SQRT  = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_SCAN  = 4'd7;
  localparam logic [3:0] S_DIFF  = 4'd8;
  localparam logic [3:0] S_UPD   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0] state_q, state_d;
  logic [2:0] grp_q, grp_d;
  logic [1:0] k_q, k_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      grp_q   <= scs_pkg::GRP_LEN;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      grp_q   <= grp_d;
      k_q     <= k_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    grp_d          = grp_q;
    k_d            = k_q;
    cmd_o          = '0;
    cmd_o.grp      = grp_q;
    cmd_o.k        = k_q;
    result_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          if (is_query_i) begin
            cmd_o.init_scan = 1'b1;
            state_d         = S_SCAN;
          end else begin
            state_d = S_LDIFF;
          end
        end
      end
      S_LDIFF: begin
        cmd_o.load_diff = 1'b1;
        grp_d           = scs_pkg::GRP_LEN;
        k_d             = '0;
        state_d         = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc_en    = 1'b1;
        cmd_o.acc_first = (k_q == '0);
        if (k_q == scs_pkg::grp_last(grp_q)) begin
          state_d = S_POST;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = S_MUL;
        end
      end
      S_POST: begin
        k_d = '0;
        case (grp_q) inside
          scs_pkg::GRP_LEN, scs_pkg::GRP_NR, scs_pkg::GRP_NT: begin
            cmd_o.sqrt_start = 1'b1;
            state_d          = S_SQRT;
          end
          scs_pkg::GRP_DOT: begin
            cmd_o.save_dot = 1'b1;
            grp_d          = scs_pkg::GRP_LSQ;
            state_d        = S_MUL;
          end
          scs_pkg::GRP_LSQ: begin
            // projection inside the segment: cross term, else endpoint norms
            grp_d   = sts_i.in_range ? scs_pkg::GRP_CROSS : scs_pkg::GRP_NR;
            state_d = S_MUL;
          end
          scs_pkg::GRP_CROSS: begin
            cmd_o.div_start = 1'b1;
            state_d         = S_DIV;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_SQRT: begin
        if (sts_i.sqrt_done) begin
          case (grp_q)
            scs_pkg::GRP_LEN: begin
              cmd_o.wr_len = 1'b1;
              state_d      = S_DONE;
            end
            scs_pkg::GRP_NR: begin
              cmd_o.save_n1 = 1'b1;
              grp_d         = scs_pkg::GRP_NT;
              k_d           = '0;
              state_d       = S_MUL;
            end
            default: begin
              cmd_o.set_d_norm = 1'b1;
              state_d          = S_UPD;
            end
          endcase
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.set_d_div = 1'b1;
          state_d         = S_UPD;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = S_DONE;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd_o.load_diff = 1'b1;
        k_d             = '0;
        grp_d           = sts_i.len_pos ? scs_pkg::GRP_DOT : scs_pkg::GRP_NR;
        state_d         = S_MUL;
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = S_SCAN;
      end
      S_DONE: begin
        result_valid_o = 1'b1;
        state_d        = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  a_result_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> (state_q == S_IDLE))
    else $error("controller did not return to idle after a result");

  a_accept_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted word did not make the block busy");

endmodule

[rtl/core/segment_clearance_scan_unit.sv]
// Top level of the segment clearance scan unit.
//
// Command channel: a word on item_i is taken at a clock edge with start high
// and busy low. A load word writes one table entry and its length; a query
// word scans the first min(segments_in_use, TABLE_DEPTH) entries against a
// point and a threshold. Every word gives one result on result_o, shown for
// exactly one cycle with result_valid_o high; the receiver cannot stall it.
// Configuration: segments_in_use is written through cfg_valid_i/cfg_data_i,
// always ready; write it only while busy is low.
// Sequencing: a load shows its result after the 32-step square root of its
// length. A query scans each entry through one shared 32x32 multiplier,
// then either the 64-step divider or two 32-step square roots. One word is
// in flight at a time; start is taken again the cycle after the result.
// Reset clears the controller, the scan state and segments_in_use; table
// entries hold no defined value until they are loaded.
module segment_clearance_scan_unit #(
  parameter int TABLE_DEPTH   = scs_pkg::TABLE_DEPTH_DEF,
  parameter int FRACTION_BITS = scs_pkg::FRACTION_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  scs_pkg::scs_in_t          item_i,
  output logic                      result_valid_o,
  output scs_pkg::scs_res_t         result_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [scs_pkg::CFG_W-1:0] cfg_data_i
);

  scs_pkg::scs_cmd_t cmd;
  scs_pkg::scs_sts_t sts;

  assign cfg_ready_o = 1'b1;

  scs_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .is_query_i     (item_i.command == scs_pkg::CMD_QUERY),
    .sts_i          (sts),
    .busy_o         (busy),
    .result_valid_o (result_valid_o),
    .cmd_o          (cmd)
  );

  scs_dpath #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_i),
    .cmd_i      (cmd),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .sts_o      (sts),
    .result_o   (result_o)
  );

endmodule

[tb/sv/segment_clearance_scan_unit_tb.sv]
// Self-checking testbench of the segment clearance scan unit: table loads, scans and count writes.
module segment_clearance_scan_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 256;
  localparam int FBITS = 16;
  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;

  class clearance_board;
    int                 prox_x[DEPTH], prox_y[DEPTH], prox_z[DEPTH];
    int                 dist_x[DEPTH], dist_y[DEPTH], dist_z[DEPTH];
    int                 seg_len[DEPTH];
    int unsigned        scan_count;
    scs_pkg::scs_res_t  expected_results[$];
    int                 mismatches;
    int                 results_seen;

    function longint clamp_diff(longint a, longint b);
      longint d;
      d = a - b;
      if (d > QMAX) return QMAX;
      if (d < QMIN) return QMIN;
      return d;
    endfunction

    function bit [63:0] mag(longint a);
      return (a < 0) ? 64'(-a) : 64'(a);
    endfunction

    function longint qmul(longint a, longint b);
      bit [63:0] p;
      p = (mag(a) * mag(b)) >> FBITS;
      return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function bit [63:0] root64(bit [63:0] x);
      bit [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint norm(longint a, longint b, longint c);
      bit [63:0] r;
      r = root64(mag(a) * mag(a) + mag(b) * mag(b) + mag(c) * mag(c));
      return (r > 64'(QMAX)) ? QMAX : longint'(r);
    endfunction

    function longint clearance(int i, longint qx, longint qy, longint qz);
      longint sx, sy, sz, rx, ry, rz, dot, lsq, crs, dd, dp, len;
      bit [63:0] q;
      len = seg_len[i];
      sx = clamp_diff(prox_x[i], dist_x[i]);
      sy = clamp_diff(prox_y[i], dist_y[i]);
      sz = clamp_diff(prox_z[i], dist_z[i]);
      rx = clamp_diff(qx, dist_x[i]);
      ry = clamp_diff(qy, dist_y[i]);
      rz = clamp_diff(qz, dist_z[i]);
      if (len > 0) begin
        dot = qmul(sx, rx) + qmul(sy, ry) + qmul(sz, rz);
        lsq = qmul(len, len);
        if (dot >= 0 && dot <= lsq) begin
          crs = qmul(clamp_diff(dist_y[i], prox_y[i]), rx) + qmul(sx, ry) + qmul(sz, rz);
          q = (mag(crs) << FBITS) / 64'(len);
          return (q > 64'(QMAX)) ? QMAX : longint'(q);
        end
      end
      dd = norm(rx, ry, rz);
      dp = norm(clamp_diff(qx, prox_x[i]), clamp_diff(qy, prox_y[i]),
                clamp_diff(qz, prox_z[i]));
      return (dd < dp) ? dd : dp;
    endfunction

    function void note_word(scs_pkg::scs_in_t w);
      scs_pkg::scs_res_t r;
      longint d, best, thr;
      int n;
      r = '0;
      if (w.command == scs_pkg::CMD_LOAD) begin
        prox_x[w.slot] = w.first_x;
        prox_y[w.slot] = w.first_y;
        prox_z[w.slot] = w.first_z;
        dist_x[w.slot] = w.second_x;
        dist_y[w.slot] = w.second_y;
        dist_z[w.slot] = w.second_z;
        seg_len[w.slot] = int'(norm(clamp_diff(w.first_x, w.second_x),
                                    clamp_diff(w.first_y, w.second_y),
                                    clamp_diff(w.first_z, w.second_z)));
      end else begin
        n = (scan_count < DEPTH) ? scan_count : DEPTH;
        thr = longint'(w.threshold);
        best = 0;
        r.all_clear = 1'b1;
        for (int i = 0; i < n; i++) begin
          d = clearance(i, w.first_x, w.first_y, w.first_z);
          if (!(d > thr)) r.all_clear = 1'b0;
          if (d > best) begin
            best = d;
            r.farthest_index = i[7:0];
            r.farthest_found = 1'b1;
          end
        end
      end
      expected_results = {expected_results, r};
    endfunction

    function void check_result(scs_pkg::scs_res_t got);
      scs_pkg::scs_res_t exp_r;
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_r = expected_results.pop_front();
      if (got.all_clear !== exp_r.all_clear || got.farthest_index !== exp_r.farthest_index ||
          got.farthest_found !== exp_r.farthest_found) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected clear=%0b idx=%0d found=%0b, got clear=%0b idx=%0d found=%0b",
                   exp_r.all_clear, exp_r.farthest_index, exp_r.farthest_found,
                   got.all_clear, got.farthest_index, got.farthest_found);
      end
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  scs_pkg::scs_in_t             item_i = '0;
  logic                         result_valid_o;
  scs_pkg::scs_res_t            result_o;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [scs_pkg::CFG_W-1:0]    cfg_data_i = '0;

  clearance_board board = new();
  int loads_sent, queries_sent, fill_next;
  bit burst;

  segment_clearance_scan_unit u_dut (
    .clk_i, .rst_ni, .start, .busy, .item_i,
    .result_valid_o, .result_o, .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) board.check_result(result_o);
  end

  task automatic send_word(scs_pkg::scs_in_t w);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= w;
    do @(posedge clk_i); while (busy);
    board.note_word(w);
    if (w.command == scs_pkg::CMD_LOAD) loads_sent++; else queries_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_count(int unsigned v);
    drain();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v[scs_pkg::CFG_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    board.scan_count = v;
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return ($urandom_range(0, 2)) == 0 ? 32'h7FFF_FFFF :
                (($urandom_range(0, 1)) ? 32'h8000_0000 : 32'h0);
      2: return 32'($urandom_range(0, 32'h0800_0000)) - 32'h0400_0000;
      default: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
    endcase
  endfunction

  function automatic logic [30:0] pick_threshold();
    case ($urandom_range(0, 3))
      0: return 31'($urandom >> 1);
      1: return 31'($urandom_range(0, 32'h0010_0000));
      2: return ($urandom_range(0, 1)) ? scs_pkg::MAX_Q31 : 31'd0;
      default: return 31'($urandom_range(0, 32'h0400_0000));
    endcase
  endfunction

  function automatic scs_pkg::scs_in_t make_word(logic cmd, logic [7:0] slot);
    scs_pkg::scs_in_t w;
    w.command  = cmd;
    w.slot     = slot;
    w.first_x  = pick_coord();
    w.first_y  = pick_coord();
    w.first_z  = pick_coord();
    w.second_x = pick_coord();
    w.second_y = pick_coord();
    w.second_z = pick_coord();
    w.threshold = pick_threshold();
    return w;
  endfunction

  function automatic scs_pkg::scs_in_t seg_word(logic [7:0] slot, int px, int py, int pz,
                                               int dx, int dy, int dz);
    scs_pkg::scs_in_t w;
    w = '0;
    w.command = scs_pkg::CMD_LOAD;
    w.slot = slot;
    w.first_x = px; w.first_y = py; w.first_z = pz;
    w.second_x = dx; w.second_y = dy; w.second_z = dz;
    return w;
  endfunction

  function automatic scs_pkg::scs_in_t point_word(int qx, int qy, int qz, logic [30:0] thr);
    scs_pkg::scs_in_t w;
    w = '0;
    w.command = scs_pkg::CMD_QUERY;
    w.first_x = qx; w.first_y = qy; w.first_z = qz;
    w.threshold = thr;
    return w;
  endfunction

  initial begin
    scs_pkg::scs_in_t w;
    int unsigned n;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty scan, then table entries covering extremes and a zero-length segment
    write_count(0);
    send_word(point_word(0, 0, 0, 31'd0));
    send_word(seg_word(8'd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                       32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000));
    send_word(seg_word(8'd1, 32'sh0003_0000, 32'sh0003_0000, 32'sh0003_0000,
                       32'sh0003_0000, 32'sh0003_0000, 32'sh0003_0000));
    send_word(seg_word(8'd2, 0, 0, 0, 32'sh000A_0000, 0, 0));
    send_word(seg_word(8'd3, -32'sh0002_0000, 32'sh0001_0000, 0,
                       32'sh0002_0000, 32'sh0005_0000, 32'sh0001_0000));
    w = make_word(scs_pkg::CMD_LOAD, 8'd255);
    send_word(w);
    write_count(4);
    send_word(point_word(32'sh0005_0000, 32'sh0002_0000, 0, 31'd0));
    send_word(point_word(32'sh0003_0000, 32'sh0003_0000, 32'sh0003_0000, 31'h0001_0000));
    send_word(point_word(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, scs_pkg::MAX_Q31));
    send_word(point_word(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 31'd0));
    send_word(point_word(0, 0, 0, 31'h0000_0001));
    send_word(point_word(-32'sh0001_0000, 32'sh0000_8000, 0, 31'h0000_4000));
    write_count(1);
    send_word(point_word(0, 0, 0, 31'd5));
    send_word(seg_word(8'd0, 0, 0, 0, 0, 32'sh0004_0000, 0));
    send_word(point_word(32'sh0001_0000, 32'sh0002_0000, 0, 31'h0000_8000));
    fill_next = 4;

    // random phases: loads fill the table in order, queries scan the loaded prefix
    for (int ph = 0; ph < 12; ph++) begin
      n = (ph % 3 == 0) ? 1 : $urandom_range(1, (fill_next < 12) ? fill_next : 12);
      write_count(n);
      burst = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 5; k++) begin
        if ($urandom_range(0, 9) < 6) begin
          if (fill_next < DEPTH) begin
            send_word(make_word(scs_pkg::CMD_LOAD, fill_next[7:0]));
            fill_next++;
          end else begin
            send_word(make_word(scs_pkg::CMD_LOAD, 8'($urandom_range(0, 255))));
          end
        end else begin
          w = make_word(scs_pkg::CMD_QUERY, 8'($urandom));
          send_word(w);
        end
      end
      burst = 1'b0;
    end
    while (fill_next < DEPTH) begin
      send_word(make_word(scs_pkg::CMD_LOAD, fill_next[7:0]));
      fill_next++;
    end

    // full table scans, including a count beyond the table
    write_count(256);
    repeat (2) send_word(make_word(scs_pkg::CMD_QUERY, 8'($urandom)));
    write_count(511);
    repeat (2) send_word(make_word(scs_pkg::CMD_QUERY, 8'($urandom)));

    drain();
    repeat (100) @(posedge clk_i);
    $display("covered %0d loads and %0d queries, scan counts from 0 to 511",
             loads_sent, queries_sent);
    $display("results checked: %0d, mismatches: %0d", board.results_seen, board.mismatches);
    if (board.mismatches == 0 && board.expected_results.size() == 0) begin
      $display("[segment_clearance_scan_unit] OK");
    end else begin
      $display("[segment_clearance_scan_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("[segment_clearance_scan_unit] ERROR");
    $finish;
  end

endmodule

[sim.f]
rtl/core/scs_pkg.sv
rtl/core/scs_isqrt.sv
rtl/core/scs_div.sv
rtl/core/scs_dpath.sv
rtl/core/scs_ctrl.sv
rtl/core/segment_clearance_scan_unit.sv
tb/sv/segment_clearance_scan_unit_tb.sv
